@@ rtl/rscv_pkg.sv @@
// Shared types, constants and codes for the stage chunk validator.
package rscv_pkg;

   localparam int STAGE_COUNT = 8;
   localparam int LENGTH_BITS = 26;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [21:0] MAX_TICKS_RESET = 22'd3600000;
   localparam logic [15:0] MIN_RATE_RESET = 16'd60;
   localparam logic [15:0] MAX_RATE_RESET = 16'd1000;

   localparam logic [1:0] CSR_MAX_TICKS = 2'd0;
   localparam logic [1:0] CSR_MIN_RATE = 2'd1;
   localparam logic [1:0] CSR_MAX_RATE = 2'd2;

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_STAGE = 3'd1;
   localparam logic [2:0] PH_BITS = 3'd2;
   localparam logic [2:0] PH_RUN = 3'd3;
   localparam logic [2:0] PH_DONE = 3'd4;

   localparam logic [2:0] ERR_OK = 3'd0;
   localparam logic [2:0] ERR_SHORT = 3'd1;
   localparam logic [2:0] ERR_TAG = 3'd2;
   localparam logic [2:0] ERR_HEADER = 3'd3;
   localparam logic [2:0] ERR_TRUNCATED = 3'd4;
   localparam logic [2:0] ERR_STAGE = 3'd5;
   localparam logic [2:0] ERR_PAIR = 3'd6;
   localparam logic [2:0] ERR_SUM = 3'd7;

   localparam logic KIND_PAIR = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam logic [7:0] TAG_BYTE0 = 8'h48;
   localparam logic [7:0] TAG_BYTE1 = 8'h46;
   localparam logic [7:0] TAG_BYTE2 = 8'h52;
   localparam logic [7:0] TAG_BYTE3 = 8'h49;

   localparam logic [LENGTH_BITS-1:0] HEADER_BYTES = LENGTH_BITS'(24);
   localparam logic [LENGTH_BITS-1:0] STAGE_HEADER_BYTES = LENGTH_BITS'(12);
   localparam logic [7:0] MAX_PAIR_BITS = 8'd31;

   typedef struct packed {
      logic [21:0] max_ticks;
      logic [15:0] min_rate;
      logic [15:0] max_rate;
   } cfg_type;

   typedef struct packed {
      logic        item_kind;
      logic [2:0]  stage_number;
      logic [4:0]  pair_bits;
      logic [7:0]  run_length;
      logic [2:0]  error_code;
      logic        last_result;
   } result_type;

   typedef struct packed {
      logic                   pair_valid;
      logic                   verdict_valid;
      result_type             pair;
      result_type             verdict;
   } push_type;

   typedef struct packed {
      logic [2:0]             phase;
      logic [LENGTH_BITS-1:0] byte_offset;
   } parser_status_type;

endpackage

@@ rtl/rscv_parser.sv @@
// Chunk parser: per-byte header, stage and pair checks with all chunk state.
module rscv_parser
   import rscv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   accept,
   input  logic [7:0]             byte_value,
   input  logic [LENGTH_BITS-1:0] chunk_length,
   input  logic                   final_byte,
   output push_type               push,
   output parser_status_type      status
);

   logic [LENGTH_BITS-1:0] offset_ff, offset_in;
   logic [2:0]             phase_ff, phase_in;
   logic [31:0]            field_ff, field_in;
   logic [3:0]             stages_left_ff, stages_left_in;
   logic [7:0]             seen_ff, seen_in;
   logic [2:0]             stage_ff, stage_in;
   logic [21:0]            tick_total_ff, tick_total_in;
   logic [LENGTH_BITS-1:0] pairs_left_ff, pairs_left_in;
   logic [21:0]            tick_sum_ff, tick_sum_in;
   logic [4:0]             held_ff, held_in;
   logic [2:0]             err_ff, err_in;

   logic [LENGTH_BITS:0]   len_diff;
   logic                   truncated;
   logic [LENGTH_BITS-1:0] bytes_left;
   logic [31:0]            field_merged;
   logic [21:0]            ticks_free;
   logic [21:0]            sum_next;
   logic [LENGTH_BITS-1:0] pairs_dec;
   logic                   finish;
   logic [21:0]            finish_sum;
   logic [3:0]             stages_dec;
   logic [2:0]             code;

   always_comb begin
      len_diff = {1'b0, chunk_length} - {1'b0, offset_ff};
      truncated = len_diff[LENGTH_BITS] || (len_diff[LENGTH_BITS-1:0] < STAGE_HEADER_BYTES);
      if (!len_diff[LENGTH_BITS] && len_diff[LENGTH_BITS-1:0] != '0) begin
         bytes_left = len_diff[LENGTH_BITS-1:0] - LENGTH_BITS'(1);
      end else begin
         bytes_left = '0;
      end
      if (phase_ff == PH_HEADER) begin
         field_merged = field_ff | ({24'd0, byte_value} << {offset_ff[1:0], 3'b000});
      end else begin
         field_merged = field_ff | ({24'd0, byte_value} << {held_ff[1:0], 3'b000});
      end
      ticks_free = tick_total_ff - tick_sum_ff;
      sum_next = tick_sum_ff + {14'd0, byte_value};
      pairs_dec = pairs_left_ff - LENGTH_BITS'(1);
      stages_dec = stages_left_ff - 4'd1;
   end

   always_comb begin
      offset_in = offset_ff;
      phase_in = phase_ff;
      field_in = field_ff;
      stages_left_in = stages_left_ff;
      seen_in = seen_ff;
      stage_in = stage_ff;
      tick_total_in = tick_total_ff;
      pairs_left_in = pairs_left_ff;
      tick_sum_in = tick_sum_ff;
      held_in = held_ff;
      err_in = err_ff;
      finish = 1'b0;
      finish_sum = '0;
      code = ERR_OK;
      push = '0;
      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               if (offset_ff == '0 && chunk_length < HEADER_BYTES) begin
                  err_in = ERR_SHORT;
                  phase_in = PH_DONE;
               end else if (offset_ff >= LENGTH_BITS'(12) && offset_ff <= LENGTH_BITS'(15)) begin
                  if ((offset_ff[1:0] == 2'd0 && byte_value != TAG_BYTE0) ||
                      (offset_ff[1:0] == 2'd1 && byte_value != TAG_BYTE1) ||
                      (offset_ff[1:0] == 2'd2 && byte_value != TAG_BYTE2) ||
                      (offset_ff[1:0] == 2'd3 && byte_value != TAG_BYTE3)) begin
                     err_in = ERR_TAG;
                     phase_in = PH_DONE;
                  end
               end else if (offset_ff >= LENGTH_BITS'(16) && offset_ff <= LENGTH_BITS'(19)) begin
                  field_in = field_merged;
               end else if (offset_ff == LENGTH_BITS'(20)) begin
                  field_in = '0;
                  if (field_ff[15:0] != 16'd1 || field_ff[31:16] < cfg.min_rate ||
                      field_ff[31:16] > cfg.max_rate || byte_value > 8'(STAGE_COUNT)) begin
                     err_in = ERR_HEADER;
                     phase_in = PH_DONE;
                  end else begin
                     stages_left_in = byte_value[3:0];
                  end
               end else if (offset_ff == LENGTH_BITS'(23)) begin
                  held_in = '0;
                  phase_in = (stages_left_ff != '0) ? PH_STAGE : PH_DONE;
               end
            end
            PH_STAGE: begin
               held_in = held_ff + 5'd1;
               if (held_ff == 5'd0) begin
                  if (truncated) begin
                     err_in = ERR_TRUNCATED;
                     phase_in = PH_DONE;
                  end else if (byte_value >= 8'(STAGE_COUNT) || seen_ff[byte_value[2:0]]) begin
                     err_in = ERR_STAGE;
                     phase_in = PH_DONE;
                  end else begin
                     stage_in = byte_value[2:0];
                     seen_in = seen_ff | (8'd1 << byte_value[2:0]);
                  end
               end else if (held_ff >= 5'd4 && held_ff <= 5'd7) begin
                  field_in = field_merged;
                  if (held_ff == 5'd7) begin
                     field_in = '0;
                     if (field_merged > {10'd0, cfg.max_ticks}) begin
                        err_in = ERR_STAGE;
                        phase_in = PH_DONE;
                     end else begin
                        tick_total_in = field_merged[21:0];
                     end
                  end
               end else if (held_ff >= 5'd8 && held_ff <= 5'd11) begin
                  field_in = field_merged;
                  if (held_ff == 5'd11) begin
                     field_in = '0;
                     if (field_merged > 32'(bytes_left >> 1)) begin
                        err_in = ERR_STAGE;
                        phase_in = PH_DONE;
                     end else begin
                        pairs_left_in = field_merged[LENGTH_BITS-1:0];
                        tick_sum_in = '0;
                        held_in = '0;
                        if (field_merged == '0) begin
                           finish = 1'b1;
                           finish_sum = '0;
                        end else begin
                           phase_in = PH_BITS;
                        end
                     end
                  end
               end
            end
            PH_BITS: begin
               if (byte_value > MAX_PAIR_BITS) begin
                  err_in = ERR_PAIR;
                  phase_in = PH_DONE;
               end else begin
                  held_in = byte_value[4:0];
                  phase_in = PH_RUN;
               end
            end
            PH_RUN: begin
               if (byte_value == 8'd0 || {14'd0, byte_value} > ticks_free) begin
                  err_in = ERR_PAIR;
                  phase_in = PH_DONE;
               end else begin
                  push.pair_valid = 1'b1;
                  push.pair.item_kind = KIND_PAIR;
                  push.pair.stage_number = stage_ff;
                  push.pair.pair_bits = held_ff;
                  push.pair.run_length = byte_value;
                  tick_sum_in = sum_next;
                  pairs_left_in = pairs_dec;
                  if (pairs_dec == '0) begin
                     finish = 1'b1;
                     finish_sum = sum_next;
                  end else begin
                     phase_in = PH_BITS;
                  end
               end
            end
            default: begin
            end
         endcase

         if (finish) begin
            if (finish_sum != tick_total_ff) begin
               err_in = ERR_SUM;
               phase_in = PH_DONE;
            end else begin
               stages_left_in = stages_dec;
               held_in = '0;
               phase_in = (stages_dec != '0) ? PH_STAGE : PH_DONE;
            end
         end

         if (offset_ff != '1) begin
            offset_in = offset_ff + LENGTH_BITS'(1);
         end

         if (final_byte) begin
            code = err_in;
            if (code == ERR_OK && phase_in != PH_DONE) begin
               code = (phase_in == PH_HEADER) ? ERR_SHORT : ERR_TRUNCATED;
            end
            push.verdict_valid = 1'b1;
            push.verdict.item_kind = KIND_VERDICT;
            push.verdict.error_code = code;
            push.verdict.last_result = 1'b1;
            offset_in = '0;
            phase_in = PH_HEADER;
            field_in = '0;
            stages_left_in = '0;
            seen_in = '0;
            stage_in = '0;
            tick_total_in = '0;
            pairs_left_in = '0;
            tick_sum_in = '0;
            held_in = '0;
            err_in = ERR_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         phase_ff <= PH_HEADER;
         field_ff <= '0;
         stages_left_ff <= '0;
         seen_ff <= '0;
         stage_ff <= '0;
         tick_total_ff <= '0;
         pairs_left_ff <= '0;
         tick_sum_ff <= '0;
         held_ff <= '0;
         err_ff <= ERR_OK;
      end else begin
         offset_ff <= offset_in;
         phase_ff <= phase_in;
         field_ff <= field_in;
         stages_left_ff <= stages_left_in;
         seen_ff <= seen_in;
         stage_ff <= stage_in;
         tick_total_ff <= tick_total_in;
         pairs_left_ff <= pairs_left_in;
         tick_sum_ff <= tick_sum_in;
         held_ff <= held_in;
         err_ff <= err_in;
      end
   end

   assign status.phase = phase_ff;
   assign status.byte_offset = offset_ff;

endmodule

@@ rtl/rscv_out_queue.sv @@
// Result queue: takes up to two result words per cycle, hands out one per pop.
module rscv_out_queue
   import rscv_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  push_type                  push,
   input  logic                      pop,
   output logic                      out_valid,
   output result_type                out_word,
   output logic [QUEUE_CNT_BITS-1:0] count
);

   result_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   result_type                first_word;
   logic [QUEUE_CNT_BITS-1:0] push_count;
   logic                      do_pop;

   always_comb begin
      first_word = push.pair_valid ? push.pair : push.verdict;
      push_count = QUEUE_CNT_BITS'(push.pair_valid) + QUEUE_CNT_BITS'(push.verdict_valid);
      do_pop = pop && (count_ff != '0);
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(push_count);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(do_pop);
      count_in = count_ff + push_count - QUEUE_CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push.pair_valid || push.verdict_valid) begin
         entry_ff[wr_ptr_ff] <= first_word;
      end
      if (push.pair_valid && push.verdict_valid) begin
         entry_ff[wr_ptr_ff + QUEUE_PTR_BITS'(1)] <= push.verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_word = entry_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

@@ rtl/rle_stage_chunk_validator_unit.sv @@
// Top level of the run-length stage chunk validator with its control registers.
//
// Takes one chunk byte per cycle while ready and checks it against the chunk
// header, stage headers and run pairs as it arrives. Each byte yields zero, one
// or two result words (a run pair, the verdict on the final byte, or both),
// written into a four-word result queue and offered from there in order. The
// byte input stays ready while the queue holds two words or fewer, so with
// the result side taking a word every cycle the block sustains one byte per
// cycle; only a byte that yields two words leaves an extra word to drain.
// Register writes are taken in any cycle and apply to the next byte.
module rle_stage_chunk_validator_unit
   import rscv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // byte_value[7:0], chunk_length[33:8], zero pad
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // stage_number[2:0], pair_bits[7:3], run_length[15:8],
                                   // error_code[18:16], zero pad
   output logic        rsp_tuser,  // item_kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [21:0] csr_data
);

   logic [21:0]               max_ticks_ff, max_ticks_in;
   logic [15:0]               min_rate_ff, min_rate_in;
   logic [15:0]               max_rate_ff, max_rate_in;
   cfg_type                   cfg;
   logic                      req_accept;
   push_type                  push;
   parser_status_type         status;
   result_type                out_word;
   logic [QUEUE_CNT_BITS-1:0] queue_count;

   always_comb begin
      max_ticks_in = max_ticks_ff;
      min_rate_in = min_rate_ff;
      max_rate_in = max_rate_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_TICKS: max_ticks_in = csr_data;
            CSR_MIN_RATE: min_rate_in = csr_data[15:0];
            CSR_MAX_RATE: max_rate_in = csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ticks_ff <= MAX_TICKS_RESET;
         min_rate_ff <= MIN_RATE_RESET;
         max_rate_ff <= MAX_RATE_RESET;
      end else begin
         max_ticks_ff <= max_ticks_in;
         min_rate_ff <= min_rate_in;
         max_rate_ff <= max_rate_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg.max_ticks = max_ticks_ff;
   assign cfg.min_rate = min_rate_ff;
   assign cfg.max_rate = max_rate_ff;

   assign req_tready = (queue_count <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));
   assign req_accept = req_tvalid && req_tready;

   rscv_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .accept       (req_accept),
      .byte_value   (req_tdata[7:0]),
      .chunk_length (req_tdata[33:8]),
      .final_byte   (req_tlast),
      .push         (push),
      .status       (status)
   );

   rscv_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_word  (out_word),
      .count     (queue_count)
   );

   assign rsp_tdata = {5'd0, out_word.error_code, out_word.run_length,
                       out_word.pair_bits, out_word.stage_number};
   assign rsp_tuser = out_word.item_kind;
   assign rsp_tlast = out_word.last_result;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_count <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_room_on_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (queue_count <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2)))
      else $error("input ready without room for two words");

   a_pair_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_PAIR) |-> (!rsp_tlast && rsp_tdata[18:16] == ERR_OK))
      else $error("run pair carries verdict fields");

   a_chunk_restart: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> (status.byte_offset == '0 && status.phase == PH_HEADER))
      else $error("chunk state not cleared after final byte");

endmodule

@@ sim/tb_rle_stage_chunk_validator_unit.sv @@
// Self-checking testbench for the run-length stage chunk validator: directed and random chunks.
module tb_rle_stage_chunk_validator_unit;

   timeunit 1ns;
   timeprecision 1ps;

   import rscv_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [21:0] csr_data;

   rle_stage_chunk_validator_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   class chunk_scoreboard;
      logic [21:0] max_ticks;
      logic [15:0] min_rate;
      logic [15:0] max_rate;
      logic [LENGTH_BITS-1:0] offset;
      logic [2:0]  phase;
      logic [31:0] shift;
      logic [3:0]  stages_left;
      logic [7:0]  seen;
      logic [2:0]  cur_stage;
      logic [21:0] tick_total;
      logic [LENGTH_BITS-1:0] pairs_left;
      logic [21:0] tick_sum;
      logic [7:0]  held;
      logic [2:0]  err;
      result_type  exp_q[$];
      int          errors;
      int          words_checked;

      function new();
         max_ticks = MAX_TICKS_RESET;
         min_rate = MIN_RATE_RESET;
         max_rate = MAX_RATE_RESET;
         errors = 0;
         words_checked = 0;
         clear_chunk();
      endfunction

      function void clear_chunk();
         offset = '0;
         phase = PH_HEADER;
         shift = '0;
         stages_left = '0;
         seen = '0;
         cur_stage = '0;
         tick_total = '0;
         pairs_left = '0;
         tick_sum = '0;
         held = '0;
         err = ERR_OK;
      endfunction

      function void set_reg(input logic [1:0] idx, input logic [21:0] val);
         case (idx)
            CSR_MAX_TICKS: max_ticks = val;
            CSR_MIN_RATE: min_rate = val[15:0];
            CSR_MAX_RATE: max_rate = val[15:0];
            default: ;
         endcase
      endfunction

      function void abort(input logic [2:0] code);
         err = code;
         phase = PH_DONE;
      endfunction

      function void close_stage();
         if (tick_sum != tick_total) begin
            abort(ERR_SUM);
            return;
         end
         stages_left = stages_left - 4'd1;
         held = '0;
         phase = (stages_left != 0) ? PH_STAGE : PH_DONE;
      endfunction

      function void push_word(input logic kind, input logic [2:0] stage, input logic [4:0] bits,
                              input logic [7:0] run, input logic [2:0] code, input logic last);
         result_type r;
         r.item_kind = kind;
         r.stage_number = stage;
         r.pair_bits = bits;
         r.run_length = run;
         r.error_code = code;
         r.last_result = last;
         exp_q.push_back(r);
      endfunction

      function void note_byte(input logic [7:0] v, input logic [LENGTH_BITS-1:0] len,
                              input logic fin);
         logic [LENGTH_BITS-1:0] pos;
         logic [31:0] k;
         logic [31:0] left;
         logic [31:0] np;
         logic [7:0]  tag_want;
         logic [2:0]  code;
         pos = offset;
         case (phase)
            PH_HEADER: begin
               if (pos == 0 && len < 24) begin
                  abort(ERR_SHORT);
               end else if (pos >= 12 && pos <= 15) begin
                  case (pos[1:0])
                     2'd0: tag_want = TAG_BYTE0;
                     2'd1: tag_want = TAG_BYTE1;
                     2'd2: tag_want = TAG_BYTE2;
                     default: tag_want = TAG_BYTE3;
                  endcase
                  if (v != tag_want) abort(ERR_TAG);
               end else if (pos >= 16 && pos <= 19) begin
                  shift = shift | (32'(v) << (8 * (pos - 16)));
               end else if (pos == 20) begin
                  if (shift[15:0] != 16'd1 || shift[31:16] < min_rate ||
                      shift[31:16] > max_rate || v > STAGE_COUNT) begin
                     abort(ERR_HEADER);
                  end else begin
                     stages_left = v[3:0];
                  end
                  shift = '0;
               end else if (pos == 23) begin
                  held = '0;
                  phase = (stages_left != 0) ? PH_STAGE : PH_DONE;
               end
            end
            PH_STAGE: begin
               k = 32'(held);
               held = held + 8'd1;
               if (k == 0) begin
                  if (pos > len || 32'(len) - 32'(pos) < 12) begin
                     abort(ERR_TRUNCATED);
                  end else if (v >= STAGE_COUNT || seen[v[2:0]]) begin
                     abort(ERR_STAGE);
                  end else begin
                     cur_stage = v[2:0];
                     seen[v[2:0]] = 1'b1;
                  end
               end else if (k >= 4 && k <= 7) begin
                  shift = shift | (32'(v) << (8 * (k - 4)));
                  if (k == 7) begin
                     if (shift > 32'(max_ticks)) abort(ERR_STAGE);
                     else tick_total = shift[21:0];
                     shift = '0;
                  end
               end else if (k >= 8 && k <= 11) begin
                  shift = shift | (32'(v) << (8 * (k - 8)));
                  if (k == 11) begin
                     left = (pos < len) ? 32'(len) - 32'(pos) - 32'd1 : 32'd0;
                     np = shift;
                     shift = '0;
                     if (np > left / 2) begin
                        abort(ERR_STAGE);
                     end else begin
                        pairs_left = np[LENGTH_BITS-1:0];
                        tick_sum = '0;
                        held = '0;
                        if (pairs_left == 0) close_stage();
                        else phase = PH_BITS;
                     end
                  end
               end
            end
            PH_BITS: begin
               if (v > MAX_PAIR_BITS) begin
                  abort(ERR_PAIR);
               end else begin
                  held = v;
                  phase = PH_RUN;
               end
            end
            PH_RUN: begin
               if (v == 0 || 32'(v) > 32'(tick_total) - 32'(tick_sum)) begin
                  abort(ERR_PAIR);
               end else begin
                  push_word(KIND_PAIR, cur_stage, held[4:0], v, ERR_OK, 1'b0);
                  tick_sum = tick_sum + 22'(v);
                  pairs_left = pairs_left - 1'b1;
                  if (pairs_left == 0) close_stage();
                  else phase = PH_BITS;
               end
            end
            default: ;
         endcase
         if (offset != '1) offset = offset + 1'b1;
         if (fin) begin
            code = err;
            if (code == ERR_OK && phase != PH_DONE)
               code = (phase == PH_HEADER) ? ERR_SHORT : ERR_TRUNCATED;
            push_word(KIND_VERDICT, 3'd0, 5'd0, 8'd0, code, 1'b1);
            clear_chunk();
         end
      endfunction

      function void check_word(input result_type got);
         result_type want;
         words_checked++;
         if (exp_q.size() == 0) begin
            $error("unexpected result word: kind %0d error_code %0d", got.item_kind,
                   got.error_code);
            errors++;
            return;
         end
         want = exp_q.pop_front();
         if (got.item_kind != want.item_kind) begin
            $error("item_kind expected %0d actual %0d", want.item_kind, got.item_kind);
            errors++;
         end
         if (got.stage_number != want.stage_number) begin
            $error("stage_number expected %0d actual %0d", want.stage_number,
                   got.stage_number);
            errors++;
         end
         if (got.pair_bits != want.pair_bits) begin
            $error("pair_bits expected %0d actual %0d", want.pair_bits, got.pair_bits);
            errors++;
         end
         if (got.run_length != want.run_length) begin
            $error("run_length expected %0d actual %0d", want.run_length, got.run_length);
            errors++;
         end
         if (got.error_code != want.error_code) begin
            $error("error_code expected %0d actual %0d", want.error_code, got.error_code);
            errors++;
         end
         if (got.last_result != want.last_result) begin
            $error("last_result expected %0d actual %0d", want.last_result, got.last_result);
            errors++;
         end
      endfunction
   endclass

   chunk_scoreboard sb;
   logic [7:0] byte_q[$];
   bit quiet;
   int bytes_sent;
   int chunks_sent;
   int settings_used;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_byte(input logic [7:0] v, input logic [LENGTH_BITS-1:0] len,
                            input logic fin);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, len, v};
      req_tlast <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(v, len, fin);
      bytes_sent++;
   endtask

   task automatic send_chunk(input logic [LENGTH_BITS-1:0] len, input int last_idx,
                             input bit len_noise);
      logic [LENGTH_BITS-1:0] l;
      for (int i = 0; i <= last_idx; i++) begin
         l = (len_noise && $urandom_range(0, 3) == 0) ? LENGTH_BITS'($urandom) : len;
         send_byte(byte_q[i], l, i == last_idx);
      end
      chunks_sent++;
   endtask

   task automatic set_word(input int at, input logic [31:0] val);
      for (int i = 0; i < 4; i++) byte_q[at + i] = val[8*i +: 8];
   endtask

   task automatic push_word32(input logic [31:0] val);
      for (int i = 0; i < 4; i++) byte_q.push_back(val[8*i +: 8]);
   endtask

   // Build a well-formed chunk for the current register settings.
   task automatic make_good_chunk(input int nst, input int minp, input int maxp);
      int perm[8];
      int j;
      int tmp;
      int np;
      logic [31:0] sum;
      logic [15:0] rate;
      logic [7:0] pair_q[$];
      byte_q.delete();
      repeat (12) byte_q.push_back(8'($urandom));
      byte_q.push_back(TAG_BYTE0);
      byte_q.push_back(TAG_BYTE1);
      byte_q.push_back(TAG_BYTE2);
      byte_q.push_back(TAG_BYTE3);
      byte_q.push_back(8'd1);
      byte_q.push_back(8'd0);
      rate = 16'($urandom_range(sb.min_rate, sb.max_rate));
      byte_q.push_back(rate[7:0]);
      byte_q.push_back(rate[15:8]);
      byte_q.push_back(8'(nst));
      repeat (3) byte_q.push_back(8'($urandom));
      for (int i = 0; i < 8; i++) perm[i] = i;
      for (int i = 7; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = perm[i];
         perm[i] = perm[j];
         perm[j] = tmp;
      end
      for (int s = 0; s < nst; s++) begin
         np = $urandom_range(minp, maxp);
         sum = '0;
         pair_q.delete();
         for (int p = 0; p < np; p++) begin
            pair_q.push_back(8'($urandom_range(0, 31)));
            pair_q.push_back(8'($urandom_range(1, 255)));
            sum = sum + 32'(pair_q[2*p + 1]);
         end
         if (sum > 32'(sb.max_ticks)) begin
            np = 0;
            sum = '0;
            pair_q.delete();
         end
         byte_q.push_back(8'(perm[s]));
         repeat (3) byte_q.push_back(8'($urandom));
         push_word32(sum);
         push_word32(32'(np));
         foreach (pair_q[p]) byte_q.push_back(pair_q[p]);
      end
      repeat ($urandom_range(0, 2)) byte_q.push_back(8'($urandom));
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      while (sb.exp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_regs(input logic [21:0] ticks_val, input logic [21:0] lo_val,
                               input logic [21:0] hi_val);
      logic [1:0]  idx[3];
      logic [21:0] vals[3];
      idx[0] = CSR_MAX_TICKS;
      idx[1] = CSR_MIN_RATE;
      idx[2] = CSR_MAX_RATE;
      vals[0] = ticks_val;
      vals[1] = lo_val;
      vals[2] = hi_val;
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.set_reg(idx[i], vals[i]);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic run_directed();
      logic [31:0] ticks;
      // length below header size on the first byte
      byte_q.delete();
      byte_q.push_back(8'h00);
      send_chunk('0, 0, 1'b0);
      // final byte inside the header
      make_good_chunk(1, 1, 2);
      send_chunk(byte_q.size(), 15, 1'b0);
      // bad tag
      make_good_chunk(1, 1, 2);
      byte_q[14] = byte_q[14] ^ 8'h01;
      send_chunk(byte_q.size(), byte_q.size() - 1, 1'b0);
      // bad version
      make_good_chunk(0, 0, 0);
      byte_q[16] = 8'd2;
      send_chunk(byte_q.size(), byte_q.size() - 1, 1'b0);
      // rate at and past both bounds
      for (int r = 0; r < 4; r++) begin
         make_good_chunk(1, 0, 1);
         case (r)
            0: {byte_q[19], byte_q[18]} = sb.min_rate;
            1: {byte_q[19], byte_q[18]} = sb.max_rate;
            2: {byte_q[19], byte_q[18]} = sb.min_rate - 16'd1;
            default: {byte_q[19], byte_q[18]} = sb.max_rate + 16'd1;
         endcase
         send_chunk(byte_q.size(), byte_q.size() - 1, 1'b0);
      end
      // too many stages
      make_good_chunk(0, 0, 0);
      byte_q[20] = 8'(STAGE_COUNT + 1);
      send_chunk(byte_q.size(), byte_q.size() - 1, 1'b0);
      // zero stages, then all stages
      make_good_chunk(0, 0, 0);
      send_chunk(byte_q.size(), byte_q.size() - 1, 1'b0);
      make_good_chunk(STAGE_COUNT, 1, 3);
      send_chunk(byte_q.size(), byte_q.size() - 1, 1'b0);
      // final byte in the middle of a stage
      make_good_chunk(2, 1, 2);
      send_chunk(byte_q.size(), 38, 1'b0);
      // length leaves no room for the stage header
      make_good_chunk(1, 0, 0);
      send_chunk(30, byte_q.size() - 1, 1'b0);
      // stage number out of range, then repeated
      make_good_chunk(1, 1, 1);
      byte_q[24] = 8'(STAGE_COUNT);
      send_chunk(byte_q.size(), byte_q.size() - 1, 1'b0);
      make_good_chunk(2, 0, 0);
      byte_q[36] = byte_q[24];
      send_chunk(byte_q.size(), byte_q.size() - 1, 1'b0);
      // tick count above limit
      make_good_chunk(1, 0, 0);
      set_word(28, 32'(sb.max_ticks) + 32'd1);
      send_chunk(byte_q.size(), byte_q.size() - 1, 1'b0);
      // pair count larger than the bytes left
      make_good_chunk(1, 0, 0);
      set_word(32, 32'd200);
      send_chunk(byte_q.size(), byte_q.size() - 1, 1'b0);
      // bits too wide, zero run
      make_good_chunk(1, 2, 2);
      byte_q[36] = MAX_PAIR_BITS + 8'd1;
      send_chunk(byte_q.size(), byte_q.size() - 1, 1'b0);
      make_good_chunk(1, 2, 2);
      byte_q[37] = 8'd0;
      send_chunk(byte_q.size(), byte_q.size() - 1, 1'b0);
      // run overshoots the tick count, then falls short of it
      make_good_chunk(1, 1, 3);
      ticks = {byte_q[31], byte_q[30], byte_q[29], byte_q[28]};
      set_word(28, ticks - 32'd1);
      send_chunk(byte_q.size(), byte_q.size() - 1, 1'b0);
      make_good_chunk(1, 1, 3);
      set_word(28, ticks + 32'd1);
      send_chunk(byte_q.size(), byte_q.size() - 1, 1'b0);
      // widest pair with the largest chunk length
      make_good_chunk(1, 1, 1);
      byte_q[36] = MAX_PAIR_BITS;
      byte_q[37] = 8'd255;
      set_word(28, 32'd255);
      send_chunk('1, byte_q.size() - 1, 1'b0);
   endtask

   task automatic run_random(input int stop_at);
      int sel;
      int nst;
      int last_idx;
      logic [LENGTH_BITS-1:0] len;
      bit noise;
      while (bytes_sent < stop_at) begin
         sel = $urandom_range(0, 99);
         nst = ($urandom_range(0, 9) == 0) ? $urandom_range(4, STAGE_COUNT) : $urandom_range(0, 2);
         make_good_chunk(nst, 0, $urandom_range(0, 4));
         last_idx = byte_q.size() - 1;
         len = byte_q.size();
         noise = 1'b0;
         if (sel < 60) begin
         end else if (sel < 72) begin
            byte_q[$urandom_range(0, last_idx)] ^= 8'($urandom_range(1, 255));
         end else if (sel < 82) begin
            last_idx = $urandom_range(0, last_idx);
         end else if (sel < 90) begin
            if ($urandom_range(0, 1) == 1) len = LENGTH_BITS'($urandom);
            else len = LENGTH_BITS'(byte_q.size() + $urandom_range(0, 30) - 15);
         end else if (sel < 95) begin
            noise = 1'b1;
         end else begin
            byte_q.delete();
            repeat ($urandom_range(1, 30)) byte_q.push_back(8'($urandom));
            last_idx = byte_q.size() - 1;
            len = LENGTH_BITS'($urandom);
         end
         send_chunk(len, last_idx, noise);
      end
   endtask

   initial begin : receiver
      int stall;
      result_type got;
      stall = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.item_kind = rsp_tuser;
            got.stage_number = rsp_tdata[2:0];
            got.pair_bits = rsp_tdata[7:3];
            got.run_length = rsp_tdata[15:8];
            got.error_code = rsp_tdata[18:16];
            got.last_result = rsp_tlast;
            sb.check_word(got);
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 5) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      sb = new();
      quiet = 1'b0;
      bytes_sent = 0;
      chunks_sent = 0;
      settings_used = 1;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= CSR_MAX_TICKS;
      csr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();

      hold_until_drained();
      program_regs(22'h3FFFFF, {6'h3F, 16'd0}, {6'h15, 16'hFFFF});
      run_random(bytes_sent + 60);
      hold_until_drained();
      program_regs(22'd0, {6'h00, 16'hFFFF}, {6'h2A, 16'hFFFF});
      run_random(bytes_sent + 60);
      hold_until_drained();
      program_regs(22'd500, {6'h0C, 16'd100}, {6'h00, 16'd200});
      run_random(bytes_sent + 60);
      hold_until_drained();
      program_regs(MAX_TICKS_RESET, 22'(MAX_RATE_RESET), 22'(MIN_RATE_RESET));
      run_random(bytes_sent + 30);
      hold_until_drained();
      program_regs(MAX_TICKS_RESET, 22'(MIN_RATE_RESET), 22'(MAX_RATE_RESET));
      quiet = 1'b1;
      run_random(bytes_sent + 80);

      req_tvalid <= 1'b0;
      while (sb.exp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d chunks (%0d bytes) under %0d register settings; %0d result words checked.",
               chunks_sent, bytes_sent, settings_used, sb.words_checked);
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
